// ----- hdl/atl_pkg.sv -----
// Shared types and constants for the assembler token lexer.
// No dependencies; every other file imports this package.
package atl_pkg;

	localparam int unsigned ValueW    = 31;
	localparam int unsigned KindW     = 3;
	localparam int unsigned PosW      = 3;
	localparam int unsigned QueueDepth = 4;
	localparam int unsigned KeywordLen = 6;
	localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

	localparam logic [7:0] ChSemi  = 8'h3B;
	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChLf    = 8'h0A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChTab   = 8'h09;
	localparam logic [7:0] ChSpace = 8'h20;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUMBER  = 3'd2,
		MODE_COMMENT = 3'd3,
		MODE_HALT    = 3'd4
	} mode_t;

	typedef enum logic [KindW-1:0] {
		KIND_CHAR     = 3'd0,
		KIND_IDENT    = 3'd1,
		KIND_REPEAT   = 3'd2,
		KIND_NUMBER   = 3'd3,
		KIND_END      = 3'd4,
		KIND_ZERO     = 3'd5,
		KIND_OVERFLOW = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [ValueW-1:0] value;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		mode_t          mode;
		logic [PosW-1:0] kpos;
	} step_status_t;

	typedef struct packed {
		logic [$clog2(QueueDepth+1)-1:0] count;
		logic                            room;
	} queue_status_t;

	function automatic logic [7:0] keyword_char(input logic [PosW-1:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0:    ch = 8'h72; // r
			3'd1:    ch = 8'h65; // e
			3'd2:    ch = 8'h70; // p
			3'd3:    ch = 8'h65; // e
			3'd4:    ch = 8'h61; // a
			3'd5:    ch = 8'h74; // t
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= ChZero && c <= ChNine;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == ChSpace || (c >= ChTab && c <= ChCr);
	endfunction

endpackage

// ----- hdl/atl_if.sv -----
// Valid/ready channel interfaces for the lexer's byte input and token output.
// Depends on atl_pkg.
interface atl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_input;

	modport source (output valid, output source_byte, output end_of_input, input ready);
	modport sink   (input valid, input source_byte, input end_of_input, output ready);
endinterface

interface atl_out_if
	import atl_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [KindW-1:0]  token_kind;
	logic [ValueW-1:0] token_value;
	logic              last_of_run;

	modport source (output valid, output token_kind, output token_value, output last_of_run,
		input ready);
	modport sink   (input valid, input token_kind, input token_value, input last_of_run,
		output ready);
endinterface

// ----- hdl/atl_step.sv -----
// Lexer state registers and the per-byte step logic; emits up to two results.
// Depends on atl_pkg.
module atl_step
	import atl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         fire,
	input  logic [7:0]   source_byte,
	input  logic         end_of_input,
	output push_t        push,
	output step_status_t status
);

	mode_t             mode_q, mode_d;
	logic [ValueW-1:0] acc_q, acc_d;
	logic              ovf_q, ovf_d;
	logic [PosW-1:0]   kpos_q, kpos_d;
	logic              kmis_q, kmis_d;

	// handling of the byte as between tokens
	mode_t             idle_mode;
	logic              idle_emit;
	kind_t             idle_kind;
	logic              idle_letter;
	logic              idle_digit;
	logic              idle_rmatch;

	// keyword tracking inside an identifier
	logic              trk_match;

	// number accumulate
	logic [ValueW+3:0] acc_mul;
	logic              acc_big;

	result_t           ident_end;
	result_t           r0, r1;
	logic [1:0]        cnt;

	always_comb begin
		idle_letter = is_letter(source_byte);
		idle_digit  = is_digit(source_byte) && source_byte != ChZero;
		idle_rmatch = source_byte == keyword_char('0);
		idle_emit   = 1'b0;
		idle_kind   = KIND_CHAR;
		idle_mode   = MODE_IDLE;
		if (is_space(source_byte)) begin
			idle_mode = MODE_IDLE;
		end else if (idle_letter) begin
			idle_mode = MODE_IDENT;
			idle_emit = 1'b1;
			idle_kind = KIND_CHAR;
		end else if (source_byte == ChZero) begin
			idle_mode = MODE_HALT;
			idle_emit = 1'b1;
			idle_kind = KIND_ZERO;
		end else if (idle_digit) begin
			idle_mode = MODE_NUMBER;
		end else if (source_byte == ChSemi) begin
			idle_mode = MODE_COMMENT;
		end else begin
			idle_mode = MODE_HALT;
			idle_emit = 1'b1;
			idle_kind = KIND_END;
		end
	end

	assign trk_match = !kmis_q && (kpos_q < PosW'(KeywordLen))
		&& source_byte == keyword_char(kpos_q);

	assign acc_mul = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
		+ {ValueW'(0), source_byte[3:0]};
	assign acc_big = acc_mul > {4'd0, ValueMax};

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		ovf_d  = ovf_q;
		kpos_d = kpos_q;
		kmis_d = kmis_q;
		cnt    = 2'd0;
		r0     = '{kind: KIND_END, value: '0, last: 1'b0};
		r1     = '{kind: KIND_END, value: '0, last: 1'b1};
		ident_end = '{kind: (!kmis_q && kpos_q == PosW'(KeywordLen)) ? KIND_REPEAT : KIND_IDENT,
			value: '0, last: 1'b0};

		case (mode_q)
			MODE_IDLE, MODE_IDENT, MODE_NUMBER: begin
				if (mode_q == MODE_IDENT && !end_of_input
					&& (is_letter(source_byte) || is_digit(source_byte))) begin
					kpos_d = trk_match ? kpos_q + 3'd1 : kpos_q;
					kmis_d = trk_match ? kmis_q : 1'b1;
					cnt = 2'd1;
					r0  = '{kind: KIND_CHAR, value: ValueW'(source_byte), last: 1'b0};
				end else if (mode_q == MODE_NUMBER && !end_of_input
					&& is_digit(source_byte)) begin
					acc_d = acc_big ? ValueMax : acc_mul[ValueW-1:0];
					ovf_d = ovf_q | acc_big;
				end else if (mode_q == MODE_NUMBER && ovf_q) begin
					mode_d = MODE_HALT;
					cnt = 2'd1;
					r0  = '{kind: KIND_OVERFLOW, value: '0, last: 1'b0};
				end else begin
					// token close (if any), then the byte as between tokens
					if (mode_q == MODE_IDENT) begin
						cnt = 2'd1;
						r0  = ident_end;
					end else if (mode_q == MODE_NUMBER) begin
						cnt = 2'd1;
						r0  = '{kind: KIND_NUMBER, value: acc_q, last: 1'b0};
					end
					if (end_of_input) begin
						mode_d = MODE_HALT;
						r1 = '{kind: KIND_END, value: '0, last: 1'b1};
						cnt = cnt + 2'd1;
					end else begin
						mode_d = idle_mode;
						r1 = '{kind: idle_kind,
							value: (idle_kind == KIND_CHAR) ? ValueW'(source_byte) : '0,
							last: 1'b1};
						if (idle_emit)
							cnt = cnt + 2'd1;
						if (idle_letter) begin
							kpos_d = idle_rmatch ? 3'd1 : 3'd0;
							kmis_d = !idle_rmatch;
						end
						if (idle_digit) begin
							acc_d = ValueW'(source_byte[3:0]);
							ovf_d = 1'b0;
						end
					end
					if (cnt == 2'd1 && mode_q == MODE_IDLE)
						r0 = r1;
				end
			end
			MODE_COMMENT: begin
				if (end_of_input) begin
					mode_d = MODE_HALT;
					cnt = 2'd1;
					r0  = '{kind: KIND_END, value: '0, last: 1'b0};
				end else if (source_byte == ChLf || source_byte == ChCr) begin
					mode_d = MODE_IDLE;
				end
			end
			default: begin
			end
		endcase
		r0.last = (cnt == 2'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			ovf_q  <= 1'b0;
			kpos_q <= '0;
			kmis_q <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			ovf_q  <= ovf_d;
			kpos_q <= kpos_d;
			kmis_q <= kmis_d;
		end
	end

	assign push.count  = fire ? cnt : 2'd0;
	assign push.r0     = r0;
	assign push.r1     = r1;
	assign status.mode = mode_q;
	assign status.kpos = kpos_q;

endmodule

// ----- hdl/atl_out_queue.sv -----
// Small result queue: takes up to two results per cycle, delivers one when the receiver is ready.
// Depends on atl_pkg.
module atl_out_queue
	import atl_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	atl_out_if.source     tokens,
	output queue_status_t status
);

	localparam int unsigned PtrW = $clog2(QueueDepth);
	localparam int unsigned CntW = $clog2(QueueDepth+1);

	result_t         entry_q [QueueDepth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] count_q;
	logic            pop;
	result_t         head;

	assign pop  = tokens.valid && tokens.ready;
	assign head = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			entry_q[wr_q] <= push.r0;
		if (push.count == 2'd2)
			entry_q[wr_q + PtrW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PtrW'(push.count);
			rd_q    <= rd_q + PtrW'(pop);
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

	assign tokens.valid       = count_q != '0;
	assign tokens.token_kind  = head.kind;
	assign tokens.token_value = head.value;
	assign tokens.last_of_run = head.last;
	assign status.count       = count_q;
	assign status.room        = count_q <= CntW'(QueueDepth - 2);

endmodule

// ----- hdl/assembler_token_lexer_unit.sv -----
// Top level of the assembler token lexer: input register, step logic, result queue.
// Depends on atl_pkg, atl_if, atl_step and atl_out_queue.
//
// chars carries one source byte per transaction, or an end-of-input mark.
// tokens carries the results: identifier characters, identifier or 'repeat'
// ends, numbers, end and error codes; last_of_run marks the final result of
// the byte that caused it. A byte gives zero, one or two results.
// A byte is registered on acceptance and handled from that register once
// the queue has room; its results go through the result queue to tokens.
// One byte per cycle is sustained while the receiver takes results; the
// limit is the single result per cycle on tokens, since a byte that closes
// a token and starts another yields two. The four-entry result queue
// parts the two sides; a byte is handled only when two entries are free,
// so a stalled receiver backs up into chars.ready after a few bytes.
// Reset clears the lexer to between tokens and empties the queue. After an
// end or error result every further byte is accepted and dropped.
module assembler_token_lexer_unit
	import atl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	atl_in_if.sink    chars,
	atl_out_if.source tokens
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          eoi_s1;
	logic          go;
	push_t         push;
	step_status_t  step_status;
	queue_status_t queue_status;

	assign go          = valid_s1 && queue_status.room;
	assign chars.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (chars.ready)
			valid_s1 <= chars.valid;
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			byte_s1 <= chars.source_byte;
			eoi_s1  <= chars.end_of_input;
		end
	end

	atl_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (go),
		.source_byte  (byte_s1),
		.end_of_input (eoi_s1),
		.push         (push),
		.status       (step_status)
	);

	atl_out_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.tokens (tokens),
		.status (queue_status)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		queue_status.count <= ($bits(queue_status.count))'(QueueDepth))
		else $error("result queue over capacity");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		step_status.mode == MODE_HALT |=> step_status.mode == MODE_HALT)
		else $error("lexer left halt without reset");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.count == 2'd2 |-> (!push.r0.last && push.r1.last))
		else $error("last_of_run misplaced on two-result byte");

	a_kpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_status.kpos <= PosW'(KeywordLen))
		else $error("keyword position past keyword length");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step_status.mode == MODE_HALT |-> push.count == 2'd0)
		else $error("result produced while halted");

endmodule
